// File: rtl/srsw_pkg.sv
// shared types and constants of the selective-repeat send window
`default_nettype none

package srsw_pkg;

  localparam int SEQ_W     = 15;
  localparam int LEN_W     = 11;
  localparam int CNT_W     = 4;
  localparam int CMD_W     = 3;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 15;
  localparam int SUM_W     = SEQ_W + 1;

  // number of slots in the row; the counters are sized for it
  localparam int WINDOW_DEPTH = 8;

  localparam logic [SUM_W-1:0] SEQ_SPACE   = 16'd30720;
  localparam logic [LEN_W-1:0] MAX_CHUNK   = 11'd1024;
  localparam logic [CNT_W-1:0] RESET_LIMIT = 4'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SEQ    = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ACK     = 3'd0,
    CMD_SEND    = 3'd1,
    CMD_OFFER   = 3'd2,
    CMD_LOOKUP  = 3'd3,
    CMD_RESTART = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE = 2'd0,
    STAT_NONE = 2'd1,
    STAT_FULL = 2'd2,
    STAT_MISS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_MATCH  = 2'd1,
    S_SLIDE  = 2'd2,
    S_FINISH = 2'd3
  } state_t;

  // one held chunk
  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
    logic             acked;
  } entry_t;

  // per-cell update controls
  typedef struct packed {
    logic clear;
    logic shift;
    logic write;
    logic mark;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/selective_repeat_send_window.sv
// top level of the selective-repeat send window: control, counters and the row of slots
`default_nettype none

// Sender window of a byte-sequenced selective-repeat protocol, built as a row of
// WINDOW_DEPTH slots with slot 0 at the front. Every transfer on the input channel
// gives exactly one transfer on the output channel. Each item is registered on input
// and its result is formed in the match state; an ack that hits also marks its slot,
// then slides the acked chunks at the front off in the slide state, as the row moves one
// slot toward the front per cycle. One item is in work at a time; a finished result
// sits in the output register, and a following item is taken while it waits. The
// register port is always ready and must only be written while the block is idle. An
// offer into a full window, a send with nothing unsent and an ack of an unknown
// sequence leave the window unchanged.
module selective_repeat_send_window (
  input  wire                                  clk,
  input  wire                                  rst,
  // input channel
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire logic [srsw_pkg::CMD_W-1:0]      command,
  input  wire logic [srsw_pkg::SEQ_W-1:0]      seq_in,
  input  wire logic [srsw_pkg::LEN_W-1:0]      chunk_len,
  // output channel
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [srsw_pkg::STAT_W-1:0]          status,
  output logic [srsw_pkg::SEQ_W-1:0]           seq_out,
  output logic [srsw_pkg::LEN_W-1:0]           len_out,
  output logic [srsw_pkg::CNT_W-1:0]           occupancy,
  output logic [srsw_pkg::CNT_W-1:0]           unsent,
  // register write channel
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [srsw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [srsw_pkg::CFG_DAT_W-1:0]  cfg_data
);

  localparam int SEQ_W        = srsw_pkg::SEQ_W;
  localparam int LEN_W        = srsw_pkg::LEN_W;
  localparam int CNT_W        = srsw_pkg::CNT_W;
  localparam int SUM_W        = srsw_pkg::SUM_W;
  localparam int WINDOW_DEPTH = srsw_pkg::WINDOW_DEPTH;

  // configuration registers
  logic [CNT_W-1:0] window_limit;
  logic [SEQ_W-1:0] start_seq;

  // control state
  srsw_pkg::state_t state, state_next;
  srsw_pkg::cmd_t   op_cmd;
  logic [SEQ_W-1:0] op_seq;
  logic [LEN_W-1:0] op_len;
  logic [CNT_W-1:0] held_count, held_count_next;
  logic [CNT_W-1:0] sent_count, sent_count_next;
  logic [SEQ_W-1:0] next_seq, next_seq_next;

  // result waiting for the output register after a slide or while the output is busy
  srsw_pkg::status_t pend_status;
  logic [SEQ_W-1:0]  pend_seq;
  logic [LEN_W-1:0]  pend_len;

  srsw_pkg::status_t res_status;
  logic [SEQ_W-1:0]  res_seq;
  logic [LEN_W-1:0]  res_len;

  // row of slots
  srsw_pkg::entry_t     cell_q    [WINDOW_DEPTH];
  srsw_pkg::entry_t     cell_in   [WINDOW_DEPTH];
  srsw_pkg::cell_ctrl_t cell_ctrl [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] hit_vec;
  logic [WINDOW_DEPTH-1:0] valid_vec;
  logic [WINDOW_DEPTH-1:0] acked_vec;
  logic [WINDOW_DEPTH-1:0] match_vec;
  logic [WINDOW_DEPTH-1:0] first_vec;
  logic [WINDOW_DEPTH-1:0] tail_sel;
  logic [WINDOW_DEPTH-1:0] send_sel;
  logic [WINDOW_DEPTH-1:0] read_sel;
  logic [WINDOW_DEPTH-1:0] write_vec;
  logic [WINDOW_DEPTH-1:0] mark_vec;
  logic                    shift_all;
  logic                    clear_all;

  logic [SEQ_W-1:0] rd_seq;
  logic [LEN_W-1:0] rd_len;

  logic found;
  logic slide_go;
  logic pop;
  logic out_free;
  logic load_out;
  logic full;
  logic [SUM_W-1:0] seq_sum;
  logic [SEQ_W-1:0] seq_wrap;
  logic [SEQ_W-1:0] start_wrap;
  logic [LEN_W-1:0] len_sat;

  genvar g;
  generate
    for (g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
      if (g == WINDOW_DEPTH - 1) begin : g_last
        // the back slot takes an empty, unacked chunk on a slide
        assign cell_in[g] = '0;
      end else begin : g_mid
        assign cell_in[g] = cell_q[g+1];
      end

      assign valid_vec[g] = (32'(held_count) > g);
      assign tail_sel[g]  = (32'(held_count) == g);
      assign send_sel[g]  = (32'(sent_count) == g);
      assign acked_vec[g] = cell_q[g].acked;

      assign cell_ctrl[g].clear = clear_all;
      assign cell_ctrl[g].shift = shift_all;
      assign cell_ctrl[g].write = write_vec[g];
      assign cell_ctrl[g].mark  = mark_vec[g];

      srsw_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (cell_ctrl[g]),
        .shift_in (cell_in[g]),
        .wr_seq   (next_seq),
        .wr_len   (op_len),
        .key      (op_seq),
        .entry    (cell_q[g]),
        .hit      (hit_vec[g])
      );
    end
  endgenerate

  // oldest held slot whose sequence matches: isolate the lowest set bit
  assign match_vec = hit_vec & valid_vec;
  assign first_vec = match_vec & (~match_vec + WINDOW_DEPTH'(1));
  assign found     = |match_vec;

  assign read_sel = (op_cmd == srsw_pkg::CMD_SEND) ? send_sel : first_vec;

  always_comb begin
    rd_seq = '0;
    rd_len = '0;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      if (read_sel[i]) begin
        rd_seq = rd_seq | cell_q[i].seq;
        rd_len = rd_len | cell_q[i].len;
      end
    end
  end

  // running sequence wraps by one subtract, the sum stays below twice the space
  assign seq_sum  = {1'b0, next_seq} + {{(SUM_W-LEN_W){1'b0}}, op_len};
  assign seq_wrap = (seq_sum >= srsw_pkg::SEQ_SPACE) ?
                    SEQ_W'(seq_sum - srsw_pkg::SEQ_SPACE) : SEQ_W'(seq_sum);
  // a 15-bit start value is below twice the space as well
  assign start_wrap = ({1'b0, start_seq} >= srsw_pkg::SEQ_SPACE) ?
                      SEQ_W'({1'b0, start_seq} - srsw_pkg::SEQ_SPACE) : start_seq;

  assign len_sat = (chunk_len > srsw_pkg::MAX_CHUNK) ? srsw_pkg::MAX_CHUNK : chunk_len;

  // limit above the row depth acts as the depth, zero means always full
  assign full = (held_count >= window_limit) || (32'(held_count) >= WINDOW_DEPTH);

  assign slide_go = (op_cmd == srsw_pkg::CMD_ACK) && found;
  assign pop      = (held_count != '0) && cell_q[0].acked;
  assign out_free = !out_valid || out_ready;

  assign in_ready  = (state == srsw_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      srsw_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = srsw_pkg::S_MATCH;
        end
      end
      srsw_pkg::S_MATCH: begin
        if (slide_go) begin
          state_next = srsw_pkg::S_SLIDE;
        end else if (out_free) begin
          state_next = srsw_pkg::S_IDLE;
        end else begin
          state_next = srsw_pkg::S_FINISH;
        end
      end
      srsw_pkg::S_SLIDE: begin
        if (!pop) begin
          state_next = out_free ? srsw_pkg::S_IDLE : srsw_pkg::S_FINISH;
        end
      end
      srsw_pkg::S_FINISH: begin
        if (out_free) begin
          state_next = srsw_pkg::S_IDLE;
        end
      end
      default: state_next = srsw_pkg::S_IDLE;
    endcase
  end

  // datapath controls and counter updates
  always_comb begin
    held_count_next = held_count;
    sent_count_next = sent_count;
    next_seq_next   = next_seq;
    write_vec       = '0;
    mark_vec        = '0;
    shift_all       = 1'b0;
    clear_all       = 1'b0;
    res_status      = srsw_pkg::STAT_NONE;
    res_seq         = '0;
    res_len         = '0;
    load_out        = 1'b0;
    case (state)
      srsw_pkg::S_MATCH: begin
        case (op_cmd)
          srsw_pkg::CMD_ACK: begin
            if (found) begin
              mark_vec   = first_vec;
              res_status = srsw_pkg::STAT_DONE;
            end
          end
          srsw_pkg::CMD_SEND: begin
            if (sent_count < held_count) begin
              res_seq         = rd_seq;
              res_len         = rd_len;
              sent_count_next = sent_count + CNT_W'(1);
              res_status      = srsw_pkg::STAT_DONE;
            end
          end
          srsw_pkg::CMD_OFFER: begin
            if (full) begin
              res_status = srsw_pkg::STAT_FULL;
            end else begin
              write_vec       = tail_sel;
              held_count_next = held_count + CNT_W'(1);
              res_seq         = next_seq;
              res_len         = op_len;
              next_seq_next   = seq_wrap;
              res_status      = srsw_pkg::STAT_DONE;
            end
          end
          srsw_pkg::CMD_LOOKUP: begin
            if (found) begin
              res_seq    = rd_seq;
              res_len    = rd_len;
              res_status = srsw_pkg::STAT_DONE;
            end else begin
              res_status = srsw_pkg::STAT_MISS;
            end
          end
          srsw_pkg::CMD_RESTART: begin
            clear_all       = 1'b1;
            held_count_next = '0;
            sent_count_next = '0;
            next_seq_next   = start_wrap;
            res_status      = srsw_pkg::STAT_DONE;
          end
          default: res_status = srsw_pkg::STAT_NONE;
        endcase
        load_out = out_free && !slide_go;
      end
      srsw_pkg::S_SLIDE: begin
        if (pop) begin
          // whole row moves one slot toward the front
          shift_all       = 1'b1;
          held_count_next = held_count - CNT_W'(1);
          sent_count_next = (sent_count != '0) ? sent_count - CNT_W'(1) : sent_count;
        end else begin
          load_out = out_free;
        end
      end
      srsw_pkg::S_FINISH: begin
        load_out = out_free;
      end
      default: load_out = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= srsw_pkg::S_IDLE;
      held_count   <= '0;
      sent_count   <= '0;
      next_seq     <= '0;
      window_limit <= srsw_pkg::RESET_LIMIT;
      start_seq    <= '0;
      out_valid    <= 1'b0;
    end else begin
      state      <= state_next;
      held_count <= held_count_next;
      sent_count <= sent_count_next;
      next_seq   <= next_seq_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          srsw_pkg::CFG_WINDOW_LIMIT: window_limit <= cfg_data[CNT_W-1:0];
          srsw_pkg::CFG_START_SEQ:    start_seq    <= cfg_data[SEQ_W-1:0];
          default: ;
        endcase
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_cmd <= srsw_pkg::cmd_t'(command);
      op_seq <= seq_in;
      op_len <= len_sat;
    end
    if (state == srsw_pkg::S_MATCH) begin
      pend_status <= res_status;
      pend_seq    <= res_seq;
      pend_len    <= res_len;
    end
    if (load_out) begin
      // counts are taken after this cycle's update
      status    <= (state == srsw_pkg::S_MATCH) ? res_status : pend_status;
      seq_out   <= (state == srsw_pkg::S_MATCH) ? res_seq : pend_seq;
      len_out   <= (state == srsw_pkg::S_MATCH) ? res_len : pend_len;
      occupancy <= held_count_next;
      unsent    <= (held_count_next >= sent_count_next) ?
                   held_count_next - sent_count_next : '0;
    end
  end

`ifndef SYNTHESIS
  // never more chunks sent than held
  assert property (@(posedge clk) disable iff (rst) sent_count <= held_count)
    else $error("sent count above held count");

  // slots at or beyond the back of the window carry no acked mark
  assert property (@(posedge clk) disable iff (rst) (acked_vec & ~valid_vec) == '0)
    else $error("acked mark outside the held window");

  // held count stays within the row
  assert property (@(posedge clk) disable iff (rst) 32'(held_count) <= WINDOW_DEPTH)
    else $error("held count beyond row depth");

  // one item at a time: no transfer in the cycle after one
  assert property (@(posedge clk) disable iff (rst) (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in work");
`endif

endmodule

`default_nettype wire

// File: rtl/srsw_cell.sv
// one window slot: holds a chunk, compares its sequence, takes its neighbor's chunk on a slide
`default_nettype none

module srsw_cell (
  input  wire                              clk,
  input  wire                              rst,
  input  wire srsw_pkg::cell_ctrl_t        ctrl,
  input  wire srsw_pkg::entry_t            shift_in,
  input  wire logic [srsw_pkg::SEQ_W-1:0]  wr_seq,
  input  wire logic [srsw_pkg::LEN_W-1:0]  wr_len,
  input  wire logic [srsw_pkg::SEQ_W-1:0]  key,
  output srsw_pkg::entry_t                 entry,
  output logic                             hit
);

  logic [srsw_pkg::SEQ_W-1:0] slot_seq;
  logic [srsw_pkg::LEN_W-1:0] slot_len;
  logic                       slot_acked;

  // acked mark is control state, chunk data needs no reset
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      slot_seq <= shift_in.seq;
      slot_len <= shift_in.len;
    end else if (ctrl.write) begin
      slot_seq <= wr_seq;
      slot_len <= wr_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      slot_acked <= 1'b0;
    end else if (ctrl.shift) begin
      slot_acked <= shift_in.acked;
    end else if (ctrl.write) begin
      slot_acked <= 1'b0;
    end else if (ctrl.mark) begin
      slot_acked <= 1'b1;
    end
  end

  assign entry = {slot_seq, slot_len, slot_acked};
  assign hit   = (slot_seq == key);

endmodule

`default_nettype wire
